// ===== hw/rtl/tmsp_pkg.sv =====
// shared types, constants and helper functions for the turtle move planner
package tmsp_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int CORDIC_ITER_DEF = 16;

    localparam int UW = 28;   // cordic vector width
    localparam int AW = 27;   // cordic angle width, degrees q11.16
    localparam int MW = 58;   // serial multiplier width
    localparam int DW = 36;   // signed motor distance width

    localparam logic signed [AW-1:0] DEG180_Q16 = 27'sd11796480;
    localparam logic signed [AW-1:0] DEG360_Q16 = 27'sd23592960;
    localparam logic [15:0]          DEG360_Q7  = 16'd46080;
    localparam logic [15:0]          INV_GAIN   = 16'd39797;
    localparam logic [25:0]          TURN_DIV   = 26'd23592960;

    localparam logic [1:0] REG_SPU  = 2'd0;
    localparam logic [1:0] REG_TTR  = 2'd1;
    localparam logic [1:0] REG_BL   = 2'd2;
    localparam logic [1:0] REG_PATH = 2'd3;

    localparam logic [1:0] DIR_NEG = 2'd0;
    localparam logic [1:0] DIR_POS = 2'd1;
    localparam logic [1:0] DIR_UNK = 2'd2;

    typedef enum logic [1:0] {
        CMD_PEN_UP   = 2'd0,
        CMD_PEN_DOWN = 2'd1,
        CMD_MOVE     = 2'd2
    } t_cmd;

    typedef struct packed {
        logic                 done;
        logic signed [UW-1:0] u;
        logic signed [AW-1:0] ang;
    } t_cordic_res;

    function automatic logic signed [AW-1:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0:    atan_q16 = 27'sd2949120;
            5'd1:    atan_q16 = 27'sd1740967;
            5'd2:    atan_q16 = 27'sd919879;
            5'd3:    atan_q16 = 27'sd466945;
            5'd4:    atan_q16 = 27'sd234379;
            5'd5:    atan_q16 = 27'sd117305;
            5'd6:    atan_q16 = 27'sd58666;
            5'd7:    atan_q16 = 27'sd29335;
            5'd8:    atan_q16 = 27'sd14668;
            5'd9:    atan_q16 = 27'sd7334;
            5'd10:   atan_q16 = 27'sd3667;
            5'd11:   atan_q16 = 27'sd1833;
            5'd12:   atan_q16 = 27'sd917;
            5'd13:   atan_q16 = 27'sd458;
            5'd14:   atan_q16 = 27'sd229;
            5'd15:   atan_q16 = 27'sd115;
            5'd16:   atan_q16 = 27'sd57;
            5'd17:   atan_q16 = 27'sd29;
            5'd18:   atan_q16 = 27'sd14;
            5'd19:   atan_q16 = 27'sd7;
            5'd20:   atan_q16 = 27'sd4;
            5'd21:   atan_q16 = 27'sd2;
            5'd22:   atan_q16 = 27'sd1;
            default: atan_q16 = 27'sd0;
        endcase
    endfunction

    // backlash-compensated, saturated motor count
    function automatic logic [15:0] motor_cnt(input logic signed [DW-1:0] dist_in,
                                              input logic [1:0] dir,
                                              input logic [7:0] bl);
        logic signed [DW:0] c;
        c = (DW+1)'(dist_in);
        if (dir == DIR_NEG && dist_in > 0)
            c = c + $signed({{(DW-7){1'b0}}, bl});
        if (dir == DIR_POS && !(dist_in > 0))
            c = c - $signed({{(DW-7){1'b0}}, bl});
        if (c > 37'sd32767)
            motor_cnt = 16'h7fff;
        else if (c < -37'sd32768)
            motor_cnt = 16'h8000;
        else
            motor_cnt = c[15:0];
    endfunction

endpackage

// ===== hw/rtl/tmsp_sermul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
module tmsp_sermul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [tmsp_pkg::MW-1:0] i_a,
    input  logic [15:0]             i_b,
    output logic                    o_done,
    output logic [tmsp_pkg::MW-1:0] o_p
);
    logic [tmsp_pkg::MW-1:0] r_a, r_acc;
    logic [15:0]             r_b;
    logic [3:0]              r_cnt;
    logic                    r_run, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 4'd15) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_run) begin
            if (r_b[0])
                r_acc <= r_acc + r_a;
            r_a   <= {r_a[tmsp_pkg::MW-2:0], 1'b0};
            r_b   <= {1'b0, r_b[15:1]};
            r_cnt <= r_cnt + 4'd1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

// ===== hw/rtl/tmsp_serdiv.sv =====
// restoring divider by the turn constant, one quotient bit per cycle
module tmsp_serdiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    output logic        o_done,
    output logic [15:0] o_q
);
    logic [25:0] r_rem;
    logic [15:0] r_low, r_q;
    logic [3:0]  r_cnt;
    logic        r_run, r_done;
    logic [25:0] trial;

    assign trial = {r_rem[24:0], r_low[15]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 4'd15) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, i_num[39:16]};
            r_low <= i_num[15:0];
            r_q   <= '0;
            r_cnt <= '0;
        end else if (r_run) begin
            if (trial >= tmsp_pkg::TURN_DIV) begin
                r_rem <= trial - tmsp_pkg::TURN_DIV;
                r_q   <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_q   <= {r_q[14:0], 1'b0};
            end
            r_low <= {r_low[14:0], 1'b0};
            r_cnt <= r_cnt + 4'd1;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

// ===== hw/rtl/tmsp_cordic.sv =====
// iterative vectoring cordic, one micro-rotation per cycle
module tmsp_cordic #(
    parameter int CORDIC_ITERATIONS = tmsp_pkg::CORDIC_ITER_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [tmsp_pkg::UW-1:0] i_u,
    input  logic signed [tmsp_pkg::UW-1:0] i_v,
    input  logic signed [tmsp_pkg::AW-1:0] i_ang,
    output tmsp_pkg::t_cordic_res          o_res
);
    localparam int IW = $clog2(CORDIC_ITERATIONS);

    logic signed [tmsp_pkg::UW-1:0] r_u, r_v;
    logic signed [tmsp_pkg::AW-1:0] r_ang;
    logic [IW-1:0]                  r_i;
    logic                           r_run, r_done;
    logic signed [tmsp_pkg::UW-1:0] u_sh, v_sh;
    logic signed [tmsp_pkg::AW-1:0] atan_i;

    assign u_sh   = r_u >>> r_i;
    assign v_sh   = r_v >>> r_i;
    assign atan_i = tmsp_pkg::atan_q16(5'(r_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_i == IW'(CORDIC_ITERATIONS - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_u   <= i_u;
            r_v   <= i_v;
            r_ang <= i_ang;
            r_i   <= '0;
        end else if (r_run) begin
            if (r_v > 0) begin
                r_u   <= r_u + v_sh;
                r_v   <= r_v - u_sh;
                r_ang <= r_ang + atan_i;
            end else begin
                r_u   <= r_u - v_sh;
                r_v   <= r_v + u_sh;
                r_ang <= r_ang - atan_i;
            end
            r_i <= r_i + IW'(1);
        end
    end

    assign o_res.done = r_done;
    assign o_res.u    = r_u;
    assign o_res.ang  = r_ang;
endmodule

// ===== hw/rtl/turtle_move_to_stepper_planner.sv =====
// top level: turtle goto planner with backlash-compensated stepper commands
//
// channel  | direction | tdata                          | tuser        | tlast
// s_axis   | in        | target_x[15:0] target_y[31:16] | pen_raised   | -
// m_axis   | out       | left[15:0] right[31:16]        | command[1:0] | last
// cfg      | in        | write enable, index, 16 bit data
//
// a target at the current position gives only a pen-up; otherwise the sequencer runs the cordic,
// the multiplies and, with a turn, the divide, and skips the pen-down with the pen raised;
// the work is done by the cordic iterations, the shared 16-step serial multiplier and the serial divider.
// reset is synchronous and active low and clears position, heading and directions.
// a stalled m_axis holds the sequencer at the next command; s_axis takes a target when idle.
module turtle_move_to_stepper_planner #(
    parameter int COORD_BITS        = tmsp_pkg::COORD_BITS_DEF,
    parameter int CORDIC_ITERATIONS = tmsp_pkg::CORDIC_ITER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // target_x, target_y
    input  logic        s_axis_tuser,   // pen_raised
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // left_steps, right_steps
    output logic [1:0]  m_axis_tuser,   // command
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int SH = 16 - CW;
    localparam int UW = tmsp_pkg::UW;
    localparam int AW = tmsp_pkg::AW;
    localparam int MW = tmsp_pkg::MW;
    localparam int DW = tmsp_pkg::DW;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_PEN   = 12'b000000000010,
        S_VEC   = 12'b000000000100,
        S_MULR  = 12'b000000001000,
        S_MULA  = 12'b000000010000,
        S_MULB  = 12'b000000100000,
        S_MULT1 = 12'b000001000000,
        S_MULT2 = 12'b000010000000,
        S_DIV   = 12'b000100000000,
        S_TURN  = 12'b001000000000,
        S_PDN   = 12'b010000000000,
        S_FWD   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_spu, r_ttr, r_path;
    logic [7:0]  r_bl;
    logic signed [15:0] r_pos_x, r_pos_y, r_tx, r_ty;
    logic [15:0] r_heading, r_bear;
    logic [1:0]  r_dir_l, r_dir_r;
    logic        r_raised;
    logic signed [9:0] r_dh;
    logic [33:0] r_fwd;
    logic [15:0] r_turn;

    logic        r_ovalid, r_olast;
    logic [31:0] r_odata;
    logic [1:0]  r_ouser;

    logic s_acc, out_free, same;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign same     = (r_tx == r_pos_x) && (r_ty == r_pos_y);

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spu  <= 16'd256;
            r_ttr  <= 16'd256;
            r_bl   <= 8'd0;
            r_path <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tmsp_pkg::REG_SPU:  r_spu  <= i_cfg_data;
                tmsp_pkg::REG_TTR:  r_ttr  <= i_cfg_data;
                tmsp_pkg::REG_BL:   r_bl   <= i_cfg_data[7:0];
                tmsp_pkg::REG_PATH: r_path <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // cordic setup
    logic signed [16:0] dx, dy;
    logic signed [UW-1:0] u0, v0, cu, cv;
    logic signed [AW-1:0] cang;
    assign dx = 17'(r_tx) - 17'(r_pos_x);
    assign dy = 17'(r_ty) - 17'(r_pos_y);
    assign u0 = -(UW'(dy) <<< 8);
    assign v0 = UW'(dx) <<< 8;
    always_comb begin
        if (u0 < 0) begin
            cu   = -u0;
            cv   = -v0;
            cang = tmsp_pkg::DEG180_Q16;
        end else begin
            cu   = u0;
            cv   = v0;
            cang = '0;
        end
    end

    logic cor_start;
    tmsp_pkg::t_cordic_res cor;
    assign cor_start = (r_state == S_PEN) && out_free && !same;

    tmsp_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_u     (cu),
        .i_v     (cv),
        .i_ang   (cang),
        .o_res   (cor)
    );

    // bearing and heading difference
    logic signed [AW-1:0] ang_pos;
    logic [15:0] b_raw, bear;
    logic signed [16:0] diff;
    logic [15:0] diff_mag;
    logic signed [9:0] dh_raw, dh;
    always_comb begin
        ang_pos = (cor.ang < 0) ? cor.ang + tmsp_pkg::DEG360_Q16 : cor.ang;
        b_raw   = ang_pos[24:9];
        bear    = (b_raw >= tmsp_pkg::DEG360_Q7) ? b_raw - tmsp_pkg::DEG360_Q7 : b_raw;
        diff    = $signed({1'b0, r_heading}) - $signed({1'b0, bear});
        diff_mag = (diff < 0) ? 16'(-diff) : 16'(diff);
        dh_raw  = (diff < 0) ? -$signed({1'b0, diff_mag[15:7]})
                             : $signed({1'b0, diff_mag[15:7]});
        dh = dh_raw;
        if (dh_raw > 10'sd180)
            dh = dh_raw - 10'sd360;
        if (dh_raw < -10'sd180)
            dh = dh_raw + 10'sd360;
    end

    // shared serial multiplier and single-use serial divider
    logic          mul_start, mul_done, div_start, div_done;
    logic [MW-1:0] mul_a, mul_p;
    logic [15:0]   mul_b, div_q;
    logic [7:0]    dh_mag;
    assign dh_mag = (r_dh < 0) ? 8'(-r_dh) : 8'(r_dh);

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (r_state)
            S_VEC: begin
                mul_start = cor.done;
                mul_a     = {{(MW-UW){1'b0}}, cor.u};
                mul_b     = tmsp_pkg::INV_GAIN;
            end
            S_MULR: begin
                mul_start = mul_done;
                mul_a     = {16'd0, mul_p[MW-1:16]};
                mul_b     = r_path;
            end
            S_MULA: begin
                mul_start = mul_done;
                mul_a     = mul_p;
                mul_b     = r_spu;
            end
            S_MULB: begin
                mul_start = mul_done && (r_dh != 10'sd0);
                mul_a     = {{(MW-8){1'b0}}, dh_mag};
                mul_b     = r_ttr;
            end
            S_MULT1: begin
                mul_start = mul_done;
                mul_a     = mul_p;
                mul_b     = r_spu;
            end
            default: ;
        endcase
    end
    assign div_start = (r_state == S_MULT2) && mul_done;

    tmsp_sermul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    tmsp_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mul_p[39:0]),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // motor counts
    logic signed [DW-1:0] turn_s, fwd_s;
    logic [15:0] turn_l, turn_r, fwd_l, fwd_r;
    assign turn_s = (r_dh > 0) ? -$signed({20'd0, r_turn}) : $signed({20'd0, r_turn});
    assign fwd_s  = $signed({2'b00, r_fwd});
    assign turn_l = tmsp_pkg::motor_cnt(turn_s, r_dir_l, r_bl);
    assign turn_r = tmsp_pkg::motor_cnt(turn_s, r_dir_r, r_bl);
    assign fwd_l  = tmsp_pkg::motor_cnt(fwd_s, r_dir_l, r_bl);
    assign fwd_r  = tmsp_pkg::motor_cnt(-fwd_s, r_dir_r, r_bl);

    // sequencer
    logic emit, e_last;
    logic [1:0]  e_cmd;
    logic [31:0] e_data;
    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        e_last  = 1'b0;
        e_cmd   = tmsp_pkg::CMD_PEN_UP;
        e_data  = '0;
        case (r_state)
            S_IDLE:  if (s_acc) n_state = S_PEN;
            S_PEN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_last  = same;
                    n_state = same ? S_IDLE : S_VEC;
                end
            end
            S_VEC:   if (cor.done) n_state = S_MULR;
            S_MULR:  if (mul_done) n_state = S_MULA;
            S_MULA:  if (mul_done) n_state = S_MULB;
            S_MULB: begin
                if (mul_done) begin
                    if (r_dh != 10'sd0)
                        n_state = S_MULT1;
                    else
                        n_state = r_raised ? S_FWD : S_PDN;
                end
            end
            S_MULT1: if (mul_done) n_state = S_MULT2;
            S_MULT2: if (mul_done) n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_TURN;
            S_TURN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_cmd   = tmsp_pkg::CMD_MOVE;
                    e_data  = {turn_r, turn_l};
                    n_state = r_raised ? S_FWD : S_PDN;
                end
            end
            S_PDN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_cmd   = tmsp_pkg::CMD_PEN_DOWN;
                    n_state = S_FWD;
                end
            end
            S_FWD: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    e_cmd   = tmsp_pkg::CMD_MOVE;
                    e_data  = {fwd_r, fwd_l};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic signed [15:0] in_x, in_y;
    assign in_x = $signed(s_axis_tdata[15:0] << SH) >>> SH;
    assign in_y = $signed(s_axis_tdata[31:16] << SH) >>> SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
            r_dir_l   <= tmsp_pkg::DIR_UNK;
            r_dir_r   <= tmsp_pkg::DIR_UNK;
        end else begin
            r_state <= n_state;
            if (emit)
                r_ovalid <= 1'b1;
            else if (m_axis_tready)
                r_ovalid <= 1'b0;
            if (r_state == S_TURN && out_free) begin
                r_dir_l <= (turn_s > 0) ? tmsp_pkg::DIR_POS : tmsp_pkg::DIR_NEG;
                r_dir_r <= (turn_s > 0) ? tmsp_pkg::DIR_POS : tmsp_pkg::DIR_NEG;
            end
            if (r_state == S_FWD && out_free) begin
                r_dir_l   <= (fwd_s > 0) ? tmsp_pkg::DIR_POS : tmsp_pkg::DIR_NEG;
                r_dir_r   <= (-fwd_s > 0) ? tmsp_pkg::DIR_POS : tmsp_pkg::DIR_NEG;
                r_pos_x   <= r_tx;
                r_pos_y   <= r_ty;
                r_heading <= r_bear;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_tx     <= in_x;
            r_ty     <= in_y;
            r_raised <= s_axis_tuser;
        end
        if (r_state == S_VEC && cor.done) begin
            r_bear <= bear;
            r_dh   <= dh;
        end
        if (r_state == S_MULB && mul_done)
            r_fwd <= mul_p[57:24];
        if (r_state == S_DIV && div_done)
            r_turn <= div_q;
        if (emit) begin
            r_odata <= e_data;
            r_ouser <= e_cmd;
            r_olast <= e_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_accept_pen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_state == S_PEN)
        else $error("accepted target did not start with pen-up");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && e_last) |=> r_state == S_IDLE)
        else $error("last command not followed by idle");
    a_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MULR || r_state == S_MULA || r_state == S_MULB
                      || r_state == S_MULT1 || r_state == S_MULT2))
        else $error("multiplier finished outside a multiply step");
endmodule

// ===== test/tb_top.sv =====
// testbench for the turtle move planner: directed table, random targets, checked against a predictor
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0]   cmd;
        logic [15:0]  left;
        logic [15:0]  right;
        logic         last;
    } t_move_cmd;

    typedef struct {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic               raised;
        int                 nexp;
        t_move_cmd          e0;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = 0;
    logic [15:0] i_cfg_data = 0;

    turtle_move_to_stepper_planner uut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [15:0]        p_spu, p_ttr, p_path;
    logic [7:0]         p_bl;
    logic signed [63:0] p_x, p_y, p_head;
    logic [1:0]         p_dir [2];

    t_move_cmd cmd_q[$];
    int        errors = 0;
    int        n_items = 0, n_cmds = 0, n_turns = 0;
    int        idle_pct = 0, stall_pct = 0;
    bit        hold_off = 0;
    int        quiet = 0;
    bit        done = 0;

    function automatic logic signed [63:0] shr_floor(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] atan_tab(int i);
        logic signed [63:0] t [16] = '{2949120, 1740967, 919879, 466945, 234379, 117305,
            58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return t[i];
    endfunction

    function automatic logic [15:0] comp_count(int w, logic signed [63:0] d);
        logic signed [63:0] c;
        bit pos;
        pos = d > 0;
        c = d;
        if (p_dir[w] == tmsp_pkg::DIR_NEG && pos) c = c + 64'(p_bl);
        if (p_dir[w] == tmsp_pkg::DIR_POS && !pos) c = c - 64'(p_bl);
        p_dir[w] = pos ? tmsp_pkg::DIR_POS : tmsp_pkg::DIR_NEG;
        if (c > 32767) c = 64'sd32767;
        if (c < -32768) c = -64'sd32768;
        return c[15:0];
    endfunction

    task automatic plan_target(logic signed [15:0] tx, logic signed [15:0] ty, logic raised);
        logic signed [63:0] u, v, uo, ang, b, r, dh, s, mag;
        logic [15:0] l, rr;
        t_move_cmd c[$];
        c.push_back('{tmsp_pkg::CMD_PEN_UP, 16'd0, 16'd0, 1'b0});
        if (tx != p_x || ty != p_y) begin
            u = -(ty - p_y) * 256;
            v = (tx - p_x) * 256;
            ang = '0;
            if (u < 0) begin
                u = -u; v = -v; ang = 64'sd11796480;
            end
            for (int i = 0; i < 16; i++) begin
                uo = u;
                if (v > 0) begin
                    u = u + shr_floor(v, i); v = v - shr_floor(uo, i); ang = ang + atan_tab(i);
                end else begin
                    u = u - shr_floor(v, i); v = v + shr_floor(uo, i); ang = ang - atan_tab(i);
                end
            end
            if (ang < 0) ang = ang + 64'sd23592960;
            b = ang >>> 9;
            while (b >= 46080) b = b - 46080;
            r = (u * 39797) >>> 16;
            if (r < 0) r = '0;
            dh = (p_head - b) / 128;
            if (dh > 180) dh = dh - 360;
            if (dh < -180) dh = dh + 360;
            if (dh != 0) begin
                mag = dh < 0 ? -dh : dh;
                s = (mag * p_ttr * p_spu) / (360 * 65536);
                if (dh > 0) s = -s;
                l = comp_count(0, s);
                rr = comp_count(1, s);
                c.push_back('{tmsp_pkg::CMD_MOVE, l, rr, 1'b0});
                n_turns++;
            end
            if (!raised) c.push_back('{tmsp_pkg::CMD_PEN_DOWN, 16'd0, 16'd0, 1'b0});
            s = (r * p_path * p_spu) >>> 24;
            l = comp_count(0, s);
            rr = comp_count(1, -s);
            c.push_back('{tmsp_pkg::CMD_MOVE, l, rr, 1'b0});
            p_x = 64'(tx); p_y = 64'(ty); p_head = b;
        end
        c[c.size()-1].last = 1'b1;
        foreach (c[k]) cmd_q.push_back(c[k]);
    endtask

    task automatic send(logic signed [15:0] tx, logic signed [15:0] ty, logic raised);
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        s_axis_tdata  <= {ty, tx};
        s_axis_tuser  <= raised;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        plan_target(tx, ty, raised);
        n_items++;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        drain();
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tmsp_pkg::REG_SPU:  p_spu = val;
            tmsp_pkg::REG_TTR:  p_ttr = val;
            tmsp_pkg::REG_BL:   p_bl = val[7:0];
            tmsp_pkg::REG_PATH: p_path = val;
            default: ;
        endcase
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_move_cmd e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_cmds++;
            if (cmd_q.size() == 0) begin
                $display("%0t unexpected transfer cmd=%0d data=%h", $time, m_axis_tuser,
                         m_axis_tdata);
                errors++;
            end else begin
                e = cmd_q.pop_front();
                if (m_axis_tuser != e.cmd || m_axis_tdata != {e.right, e.left} ||
                    m_axis_tlast != e.last) begin
                    $display("%0t mismatch exp cmd=%0d l=%0d r=%0d last=%0b got cmd=%0d l=%0d r=%0d last=%0b",
                             $time, e.cmd, $signed(e.left), $signed(e.right), e.last,
                             m_axis_tuser, $signed(m_axis_tdata[15:0]),
                             $signed(m_axis_tdata[31:16]), m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG && !done) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_row mk(int x, int y, bit rz, int n, t_move_cmd e);
        t_row t;
        t.tx = 16'(x); t.ty = 16'(y); t.raised = rz; t.nexp = n; t.e0 = e;
        return t;
    endfunction

    function automatic logic signed [15:0] rnd_coord(int span);
        if (span == 0) return 16'($urandom);
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    initial begin
        t_row rows[$];
        t_move_cmd pu1;
        int phase;
        pu1 = '{tmsp_pkg::CMD_PEN_UP, 16'd0, 16'd0, 1'b1};
        p_spu = 256; p_ttr = 256; p_bl = 0; p_path = 256;
        p_x = '0; p_y = '0; p_head = '0;
        p_dir[0] = tmsp_pkg::DIR_UNK; p_dir[1] = tmsp_pkg::DIR_UNK;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // same point after reset: lone pen-up
        rows.push_back(mk(0, 0, 0, 1, pu1));
        rows.push_back(mk(0, -100, 0, 0, pu1));
        rows.push_back(mk(100, -100, 1, 0, pu1));
        rows.push_back(mk(100, -100, 1, 1, pu1));
        rows.push_back(mk(32767, 32767, 0, 0, pu1));
        rows.push_back(mk(-32768, -32768, 1, 0, pu1));
        rows.push_back(mk(-32768, 32767, 0, 0, pu1));
        rows.push_back(mk(32767, -32768, 0, 0, pu1));
        rows.push_back(mk(0, 0, 1, 0, pu1));
        rows.push_back(mk(-5, 0, 0, 0, pu1));
        rows.push_back(mk(-5, 7, 0, 0, pu1));
        rows.push_back(mk(-5, 7, 0, 1, pu1));
        foreach (rows[k]) begin
            if (rows[k].nexp != 0)
                drain();
            send(rows[k].tx, rows[k].ty, rows[k].raised);
            if (rows[k].nexp != 0) begin
                if (cmd_q.size() != rows[k].nexp || cmd_q[0] != rows[k].e0) begin
                    $display("%0t row %0d exp %0d cmds first=%h got %0d cmds first=%h",
                             $time, k, rows[k].nexp, rows[k].e0, cmd_q.size(), cmd_q[0]);
                    errors++;
                end
                drain();
            end
        end
        drain();

        write_reg(tmsp_pkg::REG_BL, 16'd255);
        write_reg(tmsp_pkg::REG_SPU, 16'hffff);
        write_reg(tmsp_pkg::REG_TTR, 16'hffff);
        write_reg(tmsp_pkg::REG_PATH, 16'hffff);
        send(16'sd0, 16'sd0, 1'b0); send(16'sd300, 16'sd300, 1'b1);
        send(16'h8000, 16'sd32767, 1'b0); send(16'sd20, -16'sd20, 1'b0);
        write_reg(tmsp_pkg::REG_SPU, 16'd0);
        send(16'sd1, 16'sd1, 1'b0); send(-16'sd1, 16'sd1, 1'b1);

        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            write_reg(tmsp_pkg::REG_SPU,
                      $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(64, 1024)));
            write_reg(tmsp_pkg::REG_TTR,
                      $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(64, 1024)));
            write_reg(tmsp_pkg::REG_BL, 16'($urandom_range(255)));
            write_reg(tmsp_pkg::REG_PATH,
                      $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(64, 1024)));
            if (phase == 3) begin
                fork
                    begin hold_off = 1; repeat (3000) @(posedge i_clk); hold_off = 0; end
                join_none
            end
            for (int k = 0; k < 55; k++) begin
                if ($urandom_range(9) == 0)
                    send(16'(p_x), 16'(p_y), 1'($urandom));
                else if ($urandom_range(4) == 0)
                    send(rnd_coord(0), rnd_coord(0), 1'($urandom));
                else
                    send(16'(p_x + rnd_coord(200)), 16'(p_y + rnd_coord(200)), 1'($urandom));
            end
            drain();
        end

        drain();
        done = 1;
        $display("covered %0d targets, %0d commands, %0d turns over 8 idle/stall phases",
                 n_items, n_cmds, n_turns);
        if (errors == 0 && cmd_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== turtle_move_to_stepper_planner.f =====
hw/rtl/tmsp_pkg.sv
hw/rtl/tmsp_sermul.sv
hw/rtl/tmsp_serdiv.sv
hw/rtl/tmsp_cordic.sv
hw/rtl/turtle_move_to_stepper_planner.sv
test/tb_top.sv
